// ===== hw/rtl/zrgr_pkg.sv =====
// ----------------------------------------------------------------------------
// zrgr_pkg
// Shared types and constants for the zero-run glyph rasterizer.
// ----------------------------------------------------------------------------
package zrgr_pkg;

    // configuration register map
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 10;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_HEIGHT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_LIMIT  = 1'd1;

    localparam logic [7:0] LINE_HEIGHT_RST = 8'd16;
    localparam logic [9:0] WRAP_LIMIT_RST  = 10'd490;

    // fixed field widths
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned WIDTH_W = 9;
    localparam int unsigned PX_X_W  = 10;
    localparam int unsigned PX_Y_W  = 12;
    localparam int unsigned CNT_W   = 9;   // skip count, 1..256

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SKIP
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture the input request
        logic emit;       // write pixel to output register, advance cursor
        logic mark;       // zero byte: open skip run
        logic run_start;  // count byte: load skip counter
        logic step;       // one skip iteration
        logic finish;     // end of request: glyph-end bookkeeping
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic pending;    // skip run open
        logic byte_zero;  // captured byte is zero
        logic out_free;   // output register can take a pixel this cycle
        logic step_done;  // current skip iteration finishes the run
    } t_sts;

endpackage

// ===== hw/rtl/zero_run_glyph_rasterizer.sv =====
// ----------------------------------------------------------------------------
// zero_run_glyph_rasterizer
// Decodes zero-run coded glyph body bytes into positioned pixel writes.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                   payload
//  input     in         i_in_valid / o_in_ready     i_data_byte, i_glyph_width,
//                                                   i_last_of_glyph
//  output    out        o_out_valid / i_out_ready   o_pixel_x, o_pixel_y, o_intensity
//  config    in         i_cfg_we (no wait)          i_cfg_index, i_cfg_data
//
//  Intensity and zero-marker bytes pass through capture and execute.
//  A run count byte passes capture and execute, then S skip iterations: one per
//  row end the run reaches, plus one if it stops inside a row; a single one
//  for widths 0 and 1. S is at most 129 (width 2, count 255, cursor off column 0).
//  An intensity byte waits in execute while the output register holds an untaken pixel.
//  Reset is synchronous, active low; it covers config, pen, cursor, run flag, out valid.
// ----------------------------------------------------------------------------
module zero_run_glyph_rasterizer #(
    parameter int unsigned COL_BITS = 10,
    parameter int unsigned ROW_BITS = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [zrgr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [zrgr_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [zrgr_pkg::BYTE_W-1:0]         i_data_byte,
    input  logic [zrgr_pkg::WIDTH_W-1:0]        i_glyph_width,
    input  logic                                i_last_of_glyph,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [zrgr_pkg::PX_X_W-1:0]         o_pixel_x,
    output logic [zrgr_pkg::PX_Y_W-1:0]         o_pixel_y,
    output logic [zrgr_pkg::BYTE_W-1:0]         o_intensity
);

    zrgr_pkg::t_cmd cmd;
    zrgr_pkg::t_sts sts;

    zrgr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    zrgr_datapath #(
        .COL_BITS (COL_BITS),
        .ROW_BITS (ROW_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_data_byte     (i_data_byte),
        .i_glyph_width   (i_glyph_width),
        .i_last_of_glyph (i_last_of_glyph),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_intensity     (o_intensity)
    );

endmodule

// ===== hw/rtl/zrgr_ctrl.sv =====
// ----------------------------------------------------------------------------
// zrgr_ctrl
// Sequencer: accepts a request, dispatches it, iterates skip runs.
// ----------------------------------------------------------------------------
module zrgr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  zrgr_pkg::t_sts  i_sts,
    output zrgr_pkg::t_cmd  o_cmd
);

    zrgr_pkg::t_state r_state;
    zrgr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= zrgr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            zrgr_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = zrgr_pkg::ST_EXEC;
                end
            end
            zrgr_pkg::ST_EXEC: begin
                if (i_sts.pending) begin
                    o_cmd.run_start = 1'b1;
                    n_state         = zrgr_pkg::ST_SKIP;
                end else if (i_sts.byte_zero) begin
                    o_cmd.mark   = 1'b1;
                    o_cmd.finish = 1'b1;
                    n_state      = zrgr_pkg::ST_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.finish = 1'b1;
                    n_state      = zrgr_pkg::ST_IDLE;
                end
            end
            zrgr_pkg::ST_SKIP: begin
                o_cmd.step = 1'b1;
                if (i_sts.step_done) begin
                    o_cmd.finish = 1'b1;
                    n_state      = zrgr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = zrgr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/zrgr_datapath.sv =====
// ----------------------------------------------------------------------------
// zrgr_datapath
// Pen/cursor state, skip-run stepper, config registers, output register.
// ----------------------------------------------------------------------------
module zrgr_datapath #(
    parameter int unsigned COL_BITS = 10,
    parameter int unsigned ROW_BITS = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [zrgr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [zrgr_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [zrgr_pkg::BYTE_W-1:0]         i_data_byte,
    input  logic [zrgr_pkg::WIDTH_W-1:0]        i_glyph_width,
    input  logic                                i_last_of_glyph,
    input  zrgr_pkg::t_cmd                      i_cmd,
    output zrgr_pkg::t_sts                      o_sts,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [zrgr_pkg::PX_X_W-1:0]         o_pixel_x,
    output logic [zrgr_pkg::PX_Y_W-1:0]         o_pixel_y,
    output logic [zrgr_pkg::BYTE_W-1:0]         o_intensity
);

    localparam int unsigned WW  = zrgr_pkg::WIDTH_W;
    localparam int unsigned CW  = zrgr_pkg::CNT_W;
    // column sums keep the carry so the wrap compare sees the full value
    localparam int unsigned SUMW = ((COL_BITS > WW) ? COL_BITS : WW) + 1;

    // configuration
    logic [7:0]          r_line_height;
    logic [9:0]          r_wrap_limit;

    // state
    logic [COL_BITS-1:0] r_pen_col,    n_pen_col;
    logic [ROW_BITS-1:0] r_pen_row,    n_pen_row;
    logic [WW-1:0]       r_cursor_col, n_cursor_col;
    logic [ROW_BITS-1:0] r_cursor_row, n_cursor_row;
    logic                r_run_pending, n_run_pending;

    // captured request and skip counter
    logic [zrgr_pkg::BYTE_W-1:0] r_byte;
    logic [WW-1:0]       r_width;
    logic                r_last;
    logic [CW-1:0]       r_cnt, n_cnt;

    // output register
    logic                r_out_valid;
    logic [zrgr_pkg::PX_X_W-1:0] r_pixel_x;
    logic [zrgr_pkg::PX_Y_W-1:0] r_pixel_y;
    logic [zrgr_pkg::BYTE_W-1:0] r_intensity;

    // pixel address
    logic [SUMW-1:0]     px_sum;
    logic [ROW_BITS-1:0] py_sum;

    // single-pixel advance
    logic [WW:0]         adv_nx;
    logic [WW-1:0]       adv_col;
    logic [ROW_BITS-1:0] adv_row;

    // skip stepper
    logic [WW-1:0]       sk_space;
    logic [WW-1:0]       sk_col;
    logic [ROW_BITS-1:0] sk_row;
    logic [CW-1:0]       sk_cnt;

    // pen advance at glyph end
    logic [SUMW-1:0]     pen_sum;

    assign px_sum = SUMW'(r_pen_col) + SUMW'(r_cursor_col);
    assign py_sum = r_pen_row + r_cursor_row;

    always_comb begin
        adv_nx = {1'b0, r_cursor_col} + (WW+1)'(1);
        if (adv_nx >= {1'b0, r_width}) begin
            adv_col = '0;
            adv_row = r_cursor_row + ROW_BITS'(1);
        end else begin
            adv_col = adv_nx[WW-1:0];
            adv_row = r_cursor_row;
        end
    end

    // One iteration moves the cursor to the end of its row, or to the end of the run.
    always_comb begin
        sk_space = r_width - r_cursor_col;
        if (r_width <= WW'(1)) begin
            // every pixel crosses a row
            sk_col = '0;
            sk_row = r_cursor_row + ROW_BITS'(r_cnt);
            sk_cnt = '0;
        end else if (r_cursor_col >= r_width) begin
            sk_col = '0;
            sk_row = r_cursor_row + ROW_BITS'(1);
            sk_cnt = r_cnt - CW'(1);
        end else if (r_cnt >= sk_space) begin
            sk_col = '0;
            sk_row = r_cursor_row + ROW_BITS'(1);
            sk_cnt = r_cnt - sk_space;
        end else begin
            sk_col = r_cursor_col + r_cnt;
            sk_row = r_cursor_row;
            sk_cnt = '0;
        end
    end

    assign pen_sum = SUMW'(r_pen_col) + SUMW'(r_width);

    always_comb begin
        n_pen_col     = r_pen_col;
        n_pen_row     = r_pen_row;
        n_cursor_col  = r_cursor_col;
        n_cursor_row  = r_cursor_row;
        n_run_pending = r_run_pending;
        n_cnt         = r_cnt;
        if (i_cmd.emit) begin
            n_cursor_col = adv_col;
            n_cursor_row = adv_row;
        end
        if (i_cmd.mark) begin
            n_run_pending = 1'b1;
        end
        if (i_cmd.run_start) begin
            n_run_pending = 1'b0;
            n_cnt         = CW'(r_byte) + CW'(1);
        end
        if (i_cmd.step) begin
            n_cursor_col = sk_col;
            n_cursor_row = sk_row;
            n_cnt        = sk_cnt;
        end
        if (i_cmd.finish && r_last) begin
            n_cursor_col  = '0;
            n_cursor_row  = '0;
            n_run_pending = 1'b0;
            if (pen_sum > SUMW'(r_wrap_limit)) begin
                n_pen_col = '0;
                n_pen_row = r_pen_row + ROW_BITS'(r_line_height);
            end else begin
                n_pen_col = pen_sum[COL_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_height <= zrgr_pkg::LINE_HEIGHT_RST;
            r_wrap_limit  <= zrgr_pkg::WRAP_LIMIT_RST;
            r_pen_col     <= '0;
            r_pen_row     <= '0;
            r_cursor_col  <= '0;
            r_cursor_row  <= '0;
            r_run_pending <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    zrgr_pkg::REG_LINE_HEIGHT: r_line_height <= i_cfg_data[7:0];
                    zrgr_pkg::REG_WRAP_LIMIT:  r_wrap_limit  <= i_cfg_data[9:0];
                    default: ;
                endcase
            end
            r_pen_col     <= n_pen_col;
            r_pen_row     <= n_pen_row;
            r_cursor_col  <= n_cursor_col;
            r_cursor_row  <= n_cursor_row;
            r_run_pending <= n_run_pending;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        if (i_cmd.load) begin
            r_byte  <= i_data_byte;
            r_width <= i_glyph_width;
            r_last  <= i_last_of_glyph;
        end
        if (i_cmd.emit) begin
            r_pixel_x   <= zrgr_pkg::PX_X_W'(px_sum[COL_BITS-1:0]);
            r_pixel_y   <= zrgr_pkg::PX_Y_W'(py_sum);
            r_intensity <= r_byte;
        end
    end

    assign o_sts.pending   = r_run_pending;
    assign o_sts.byte_zero = (r_byte == '0);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;
    assign o_sts.step_done = (sk_cnt == '0);

    assign o_out_valid = r_out_valid;
    assign o_pixel_x   = r_pixel_x;
    assign o_pixel_y   = r_pixel_y;
    assign o_intensity = r_intensity;

    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.emit, i_cmd.mark, i_cmd.run_start, i_cmd.step}))
        else $error("more than one datapath operation in a cycle");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("pixel written over an untaken result");

    a_step_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |=> (r_cursor_col == '0 || r_cursor_col < r_width))
        else $error("skip step left cursor beyond glyph width");

    a_run_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.run_start |=> (!r_run_pending && r_cnt != '0))
        else $error("skip run start did not load a count");

endmodule
